>>> src/rrg_pkg.sv
// Shared types, constants and codes of the raster region grow labeler.
`default_nettype none
package rrg_pkg;

  localparam int PIX_W   = 8;
  localparam int LABEL_W = 13;
  localparam int DELTA_W = 9;
  localparam int IW_W    = 11;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 24;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_LABELS = 4096;
  localparam int DEF_MAX_WIDTH  = 1024;

  localparam logic [DELTA_W-1:0] DELTA_RST = 9'd16;
  localparam logic [IW_W-1:0]    WIDTH_RST = 11'd640;

  localparam logic [1:0] CMD_LABEL   = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_FRAME   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DELTA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [PIX_W-1:0]   pixel;
    logic [LABEL_W-1:0] query_label;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               table_full;
  } out_t;

endpackage
`default_nettype wire

>>> src/rrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rrg_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/raster_region_grow_labeler.sv
// Top level of the raster region grow labeler: sequencer, shared multiplier and stores.
// One command beat is taken when start is high and busy is low; its single result beat
// appears on out_data with a one-cycle out_strobe, and the receiver cannot stall.
// Start-frame, unused commands and resolves of unallocated labels answer in the cycle
// after the beat and leave busy low. A resolve of an allocated label walks the parent
// links in the parent store up to the root and answers with it. A pixel is answered
// after the upper-row read when it is background, after a new segment with no labeled
// neighbor, and else after each labeled neighbor's parent chain is walked and its root's
// sum and count loaded; two close neighbors get a mean compare, and when they do not merge
// two restoring divisions with nine-bit quotients pick the closer one. One 33x24
// multiplier is shared over seven steps.
`default_nettype none
module raster_region_grow_labeler #(
  parameter int MAX_LABELS = rrg_pkg::DEF_MAX_LABELS,
  parameter int MAX_WIDTH  = rrg_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rrg_pkg::in_t                  in_data,
  output logic                               out_strobe,
  output rrg_pkg::out_t                      out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rrg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int LW  = $clog2(MAX_LABELS + 2);
  localparam int AW  = $clog2(MAX_LABELS);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = (CW + 1 > rrg_pkg::IW_W) ? CW + 1 : rrg_pkg::IW_W;
  localparam int QW  = (LW > rrg_pkg::LABEL_W) ? LW : rrg_pkg::LABEL_W;
  localparam int OW  = rrg_pkg::LABEL_W;
  localparam int SW  = rrg_pkg::SUM_W;
  localparam int NW  = rrg_pkg::CNT_W;
  localparam int MW  = SW + 1;
  localparam int PW  = MW + NW;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_UPRD   = 10'b0000000010,
    ST_WALK   = 10'b0000000100,
    ST_LDSC   = 10'b0000001000,
    ST_MUL    = 10'b0000010000,
    ST_ADD    = 10'b0000100000,
    ST_DIV    = 10'b0001000000,
    ST_MERGE  = 10'b0010000000,
    ST_NEWSEG = 10'b0100000000,
    ST_FIN    = 10'b1000000000
  } state_t;

  localparam logic [LW-1:0] MAXL = LW'(MAX_LABELS);
  localparam logic [WCW-1:0] MAXW = WCW'(MAX_WIDTH);

  state_t state_r, state_nxt;
  logic [rrg_pkg::DELTA_W-1:0] delta_r;
  logic [rrg_pkg::IW_W-1:0] iw_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [LW-1:0] left_r, left_nxt, nfl_r, nfl_nxt;
  logic first_r, first_nxt, res_r, res_nxt;
  logic [rrg_pkg::PIX_W-1:0] pix_r, pix_nxt;
  logic [LW-1:0] up_r, up_nxt, lf_r, lf_nxt, cur_r, cur_nxt;
  logic [LW-1:0] ru_r, ru_nxt, rl_r, rl_nxt, lab_r, lab_nxt;
  logic which_r, which_nxt, tgt_r, tgt_nxt, full_r, full_nxt;
  logic [SW-1:0] su_r, su_nxt, sl_r, sl_nxt;
  logic [NW-1:0] cu_r, cu_nxt, cl_r, cl_nxt;
  logic [2:0] step_r, step_nxt;
  logic [PW-1:0] prod_r, prod_nxt, x_r, x_nxt, g_r, g_nxt;
  logic [SW-1:0] gu_r, gu_nxt, gl_r, gl_nxt;
  logic [MW-1:0] dcu_r, dcu_nxt;
  logic closeu_r, closeu_nxt;
  logic [SW-1:0] rem_r, rem_nxt, dv_r, dv_nxt;
  logic [8:0] q_r, q_nxt, qu_r, qu_nxt;
  logic [3:0] dstep_r, dstep_nxt;
  logic out_strobe_r, out_strobe_nxt;
  rrg_pkg::out_t out_r, out_nxt;

  logic [MW-1:0] mul_a;
  logic [NW-1:0] mul_b;

  logic par_we, par_re, sc_we, sc_re, up_we, up_re;
  logic [AW-1:0] par_waddr, par_raddr, sc_waddr, sc_raddr;
  logic [LW-1:0] par_wdata, par_q, up_q, up_wdata;
  logic [CW-1:0] up_raddr, up_waddr;
  logic [SW-1:0] sum_wdata, sum_q;
  logic [NW-1:0] cnt_wdata, cnt_q;

  logic [WCW-1:0] w_eff, col_ext, col_inc;
  logic [LW-1:0] upl, lfl;
  logic uval, lval, pval, ge;
  logic [SW:0] sum_add;
  logic [NW:0] cnt_add;
  logic [SW-1:0] s_lo, s_hi, s_t;
  logic [NW-1:0] c_lo, c_hi, c_t;
  logic [LW-1:0] lo_id, hi_id, r_t;

  function automatic logic [PW-1:0] adiff(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [AW-1:0] ent(input logic [LW-1:0] l);
    return AW'(l - 1'b1);
  endfunction

  rrg_ram #(.W(LW), .D(MAX_LABELS)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .re(par_re), .raddr(par_raddr), .rdata(par_q)
  );

  rrg_ram #(.W(SW), .D(MAX_LABELS)) u_sum (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sum_wdata),
    .re(sc_re), .raddr(sc_raddr), .rdata(sum_q)
  );

  rrg_ram #(.W(NW), .D(MAX_LABELS)) u_count (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(cnt_wdata),
    .re(sc_re), .raddr(sc_raddr), .rdata(cnt_q)
  );

  rrg_ram #(.W(LW), .D(MAX_WIDTH)) u_upper (
    .clk(clk), .we(up_we), .waddr(up_waddr), .wdata(up_wdata),
    .re(up_re), .raddr(up_raddr), .rdata(up_q)
  );

  assign busy = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data = out_r;

  assign w_eff = (iw_r == '0) ? WCW'(1) :
                 (WCW'(iw_r) > MAXW) ? MAXW : WCW'(iw_r);
  assign col_ext = WCW'(col_r);
  assign col_inc = col_ext + 1'b1;
  assign upl = first_r ? '0 : up_q;
  assign lfl = (col_r == '0) ? '0 : left_r;
  assign uval = (upl != '0) && (upl < nfl_r);
  assign lval = (lfl != '0) && (lfl < nfl_r);
  assign pval = (par_q != '0) && (par_q <= MAXL);
  assign ge = (rem_r >= dv_r);

  assign lo_id = (ru_r < rl_r) ? ru_r : rl_r;
  assign hi_id = (ru_r < rl_r) ? rl_r : ru_r;
  assign s_lo = (ru_r < rl_r) ? su_r : sl_r;
  assign s_hi = (ru_r < rl_r) ? sl_r : su_r;
  assign c_lo = (ru_r < rl_r) ? cu_r : cl_r;
  assign c_hi = (ru_r < rl_r) ? cl_r : cu_r;
  assign r_t = tgt_r ? rl_r : ru_r;
  assign s_t = tgt_r ? sl_r : su_r;
  assign c_t = tgt_r ? cl_r : cu_r;

  always_comb begin
    mul_a = MW'(pix_r);
    mul_b = cu_r;
    case (step_r)
      3'd1: begin
        mul_a = MW'(delta_r);
      end
      3'd2: begin
        mul_b = cl_r;
      end
      3'd3: begin
        mul_a = MW'(delta_r);
        mul_b = cl_r;
      end
      3'd4: begin
        mul_a = MW'(su_r);
        mul_b = cl_r;
      end
      3'd5: begin
        mul_a = MW'(sl_r);
      end
      3'd6: begin
        mul_a = dcu_r;
        mul_b = cl_r;
      end
      default: begin
      end
    endcase
    prod_nxt = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    left_nxt = left_r;
    nfl_nxt = nfl_r;
    first_nxt = first_r;
    res_nxt = res_r;
    pix_nxt = pix_r;
    up_nxt = up_r;
    lf_nxt = lf_r;
    cur_nxt = cur_r;
    ru_nxt = ru_r;
    rl_nxt = rl_r;
    lab_nxt = lab_r;
    which_nxt = which_r;
    tgt_nxt = tgt_r;
    full_nxt = full_r;
    su_nxt = su_r;
    sl_nxt = sl_r;
    cu_nxt = cu_r;
    cl_nxt = cl_r;
    step_nxt = step_r;
    x_nxt = x_r;
    g_nxt = g_r;
    gu_nxt = gu_r;
    gl_nxt = gl_r;
    dcu_nxt = dcu_r;
    closeu_nxt = closeu_r;
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    q_nxt = q_r;
    qu_nxt = qu_r;
    dstep_nxt = dstep_r;
    out_strobe_nxt = 1'b0;
    out_nxt = out_r;
    par_we = 1'b0;
    par_waddr = ent(cur_r);
    par_wdata = '0;
    par_re = 1'b0;
    par_raddr = ent(cur_r);
    sc_we = 1'b0;
    sc_waddr = ent(r_t);
    sum_wdata = '0;
    cnt_wdata = '0;
    sc_re = 1'b0;
    sc_raddr = ent(cur_r);
    up_we = 1'b0;
    up_waddr = col_r;
    up_wdata = lab_r;
    up_re = 1'b0;
    up_raddr = col_r;
    sum_add = '0;
    cnt_add = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.command)
            rrg_pkg::CMD_LABEL: begin
              pix_nxt = in_data.pixel;
              up_re = 1'b1;
              if (col_ext >= w_eff) begin
                up_raddr = '0;
                col_nxt = '0;
                left_nxt = '0;
                first_nxt = 1'b0;
              end
              state_nxt = ST_UPRD;
            end
            rrg_pkg::CMD_RESOLVE: begin
              if (in_data.query_label != '0 &&
                  QW'(in_data.query_label) < QW'(nfl_r)) begin
                cur_nxt = LW'(in_data.query_label);
                par_re = 1'b1;
                par_raddr = ent(LW'(in_data.query_label));
                res_nxt = 1'b1;
                state_nxt = ST_WALK;
              end else begin
                out_strobe_nxt = 1'b1;
                out_nxt = '0;
              end
            end
            rrg_pkg::CMD_FRAME: begin
              nfl_nxt = LW'(1);
              left_nxt = '0;
              col_nxt = '0;
              first_nxt = 1'b1;
              out_strobe_nxt = 1'b1;
              out_nxt = '0;
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_nxt = '0;
            end
          endcase
        end
      end
      ST_UPRD: begin
        up_nxt = uval ? upl : '0;
        lf_nxt = lval ? lfl : '0;
        res_nxt = 1'b0;
        full_nxt = 1'b0;
        if (pix_r == '0) begin
          lab_nxt = '0;
          state_nxt = ST_FIN;
        end else if (uval) begin
          cur_nxt = upl;
          which_nxt = 1'b0;
          par_re = 1'b1;
          par_raddr = ent(upl);
          state_nxt = ST_WALK;
        end else if (lval) begin
          cur_nxt = lfl;
          which_nxt = 1'b1;
          par_re = 1'b1;
          par_raddr = ent(lfl);
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_NEWSEG;
        end
      end
      ST_WALK: begin
        if (pval) begin
          cur_nxt = par_q;
          par_re = 1'b1;
          par_raddr = ent(par_q);
        end else if (res_r) begin
          out_strobe_nxt = 1'b1;
          out_nxt.label = OW'(cur_r);
          out_nxt.table_full = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          sc_re = 1'b1;
          if (which_r) begin
            rl_nxt = cur_r;
          end else begin
            ru_nxt = cur_r;
          end
          state_nxt = ST_LDSC;
        end
      end
      ST_LDSC: begin
        if (which_r) begin
          sl_nxt = sum_q;
          cl_nxt = (cnt_q == '0) ? NW'(1) : cnt_q;
          step_nxt = '0;
          state_nxt = ST_MUL;
        end else begin
          su_nxt = sum_q;
          cu_nxt = (cnt_q == '0) ? NW'(1) : cnt_q;
          if (lf_r != '0) begin
            cur_nxt = lf_r;
            which_nxt = 1'b1;
            par_re = 1'b1;
            par_raddr = ent(lf_r);
            state_nxt = ST_WALK;
          end else begin
            step_nxt = '0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          3'd1: begin
            gu_nxt = SW'(adiff(PW'(prod_r[SW-1:0]), PW'(su_r)));
          end
          3'd2: begin
            dcu_nxt = prod_r[MW-1:0];
            closeu_nxt = (up_r != '0) && (PW'(gu_r) < prod_r);
          end
          3'd3: begin
            gl_nxt = SW'(adiff(PW'(prod_r[SW-1:0]), PW'(sl_r)));
          end
          3'd4: begin
            if ((lf_r != '0) && (PW'(gl_r) < prod_r)) begin
              if (!closeu_r) begin
                tgt_nxt = 1'b1;
                state_nxt = ST_ADD;
              end else if (ru_r == rl_r) begin
                lab_nxt = ru_r;
                state_nxt = ST_FIN;
              end
            end else if (closeu_r) begin
              tgt_nxt = 1'b0;
              state_nxt = ST_ADD;
            end else begin
              state_nxt = ST_NEWSEG;
            end
          end
          3'd5: begin
            x_nxt = prod_r;
          end
          3'd6: begin
            g_nxt = adiff(x_r, prod_r);
          end
          3'd7: begin
            if (g_r < prod_r) begin
              state_nxt = ST_MERGE;
            end else begin
              rem_nxt = gu_r;
              dv_nxt = SW'({cu_r, 8'd0});
              q_nxt = '0;
              dstep_nxt = '0;
              which_nxt = 1'b0;
              state_nxt = ST_DIV;
            end
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        rem_nxt = ge ? rem_r - dv_r : rem_r;
        q_nxt = {q_r[7:0], ge};
        dv_nxt = dv_r >> 1;
        dstep_nxt = dstep_r + 1'b1;
        if (dstep_r == 4'd8) begin
          if (!which_r) begin
            qu_nxt = {q_r[7:0], ge};
            rem_nxt = gl_r;
            dv_nxt = SW'({cl_r, 8'd0});
            q_nxt = '0;
            dstep_nxt = '0;
            which_nxt = 1'b1;
          end else begin
            tgt_nxt = !(qu_r < {q_r[7:0], ge});
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        sum_add = {1'b0, s_t} + (SW + 1)'(pix_r);
        cnt_add = {1'b0, c_t} + 1'b1;
        sc_we = 1'b1;
        sc_waddr = ent(r_t);
        sum_wdata = sum_add[SW] ? '1 : sum_add[SW-1:0];
        cnt_wdata = cnt_add[NW] ? '1 : cnt_add[NW-1:0];
        lab_nxt = tgt_r ? lf_r : up_r;
        state_nxt = ST_FIN;
      end
      ST_MERGE: begin
        sum_add = {1'b0, s_lo} + {1'b0, s_hi};
        cnt_add = {1'b0, c_lo} + {1'b0, c_hi};
        par_we = 1'b1;
        par_waddr = ent(hi_id);
        par_wdata = lo_id;
        sc_we = 1'b1;
        sc_waddr = ent(lo_id);
        sum_wdata = sum_add[SW] ? '1 : sum_add[SW-1:0];
        cnt_wdata = cnt_add[NW] ? '1 : cnt_add[NW-1:0];
        lab_nxt = lo_id;
        state_nxt = ST_FIN;
      end
      ST_NEWSEG: begin
        if (nfl_r > MAXL) begin
          full_nxt = 1'b1;
          lab_nxt = '0;
        end else begin
          par_we = 1'b1;
          par_waddr = ent(nfl_r);
          par_wdata = '0;
          sc_we = 1'b1;
          sc_waddr = ent(nfl_r);
          sum_wdata = SW'(pix_r);
          cnt_wdata = NW'(1);
          lab_nxt = nfl_r;
          nfl_nxt = nfl_r + 1'b1;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        up_we = 1'b1;
        up_waddr = col_r;
        up_wdata = lab_r;
        if (col_inc >= w_eff) begin
          col_nxt = '0;
          left_nxt = '0;
          first_nxt = 1'b0;
        end else begin
          col_nxt = CW'(col_inc);
          left_nxt = lab_r;
        end
        out_strobe_nxt = 1'b1;
        out_nxt.label = OW'(lab_r);
        out_nxt.table_full = full_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      delta_r <= rrg_pkg::DELTA_RST;
      iw_r <= rrg_pkg::WIDTH_RST;
      col_r <= '0;
      left_r <= '0;
      nfl_r <= LW'(1);
      first_r <= 1'b1;
      res_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r <= col_nxt;
      left_r <= left_nxt;
      nfl_r <= nfl_nxt;
      first_r <= first_nxt;
      res_r <= res_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we && cfg_index == rrg_pkg::REG_DELTA) begin
        delta_r <= cfg_data[rrg_pkg::DELTA_W-1:0];
      end
      if (cfg_we && cfg_index == rrg_pkg::REG_WIDTH) begin
        iw_r <= cfg_data[rrg_pkg::IW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    up_r <= up_nxt;
    lf_r <= lf_nxt;
    cur_r <= cur_nxt;
    ru_r <= ru_nxt;
    rl_r <= rl_nxt;
    lab_r <= lab_nxt;
    which_r <= which_nxt;
    tgt_r <= tgt_nxt;
    full_r <= full_nxt;
    su_r <= su_nxt;
    sl_r <= sl_nxt;
    cu_r <= cu_nxt;
    cl_r <= cl_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    x_r <= x_nxt;
    g_r <= g_nxt;
    gu_r <= gu_nxt;
    gl_r <= gl_nxt;
    dcu_r <= dcu_nxt;
    closeu_r <= closeu_nxt;
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
    q_r <= q_nxt;
    qu_r <= qu_nxt;
    dstep_r <= dstep_nxt;
    out_r <= out_nxt;
  end

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.table_full |-> out_data.label == '0)
    else $error("table_full beat carries a nonzero label");

  a_next_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    nfl_r != '0 && nfl_r <= MAXL + 1'b1)
    else $error("next free label out of range");

  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.command == rrg_pkg::CMD_LABEL |=> busy && !out_strobe)
    else $error("pixel beat did not start the sequencer");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy || start))
    else $error("result beat without a command");

endmodule
`default_nettype wire

>>> tb/rrg_checker.sv
// Checker for the raster region grow labeler: watches the channels, predicts and compares.
module rrg_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  rrg_pkg::in_t                       in_data,
  input  logic                               out_strobe,
  input  rrg_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [rrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrg_pkg::CFG_W-1:0]          cfg_data,
  output int                                 fail_count,
  output int                                 pending
);

  localparam int NLAB = rrg_pkg::DEF_MAX_LABELS;
  localparam int NCOL = rrg_pkg::DEF_MAX_WIDTH;

  logic [rrg_pkg::LABEL_W-1:0] seg_parent [NLAB];
  logic [rrg_pkg::SUM_W-1:0]   seg_sum    [NLAB];
  logic [rrg_pkg::CNT_W-1:0]   seg_cnt    [NLAB];
  logic [rrg_pkg::LABEL_W-1:0] row_above  [NCOL];
  int unsigned                 left_lab;
  int unsigned                 next_lab;
  int unsigned                 col;
  bit                          top_row;
  logic [rrg_pkg::DELTA_W-1:0] delta;
  logic [rrg_pkg::IW_W-1:0]    width;
  rrg_pkg::out_t               expected_beats [$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic bit in_use(int unsigned l);
    return l != 0 && l < next_lab && l <= NLAB;
  endfunction

  function automatic int unsigned root_of(int unsigned l);
    int unsigned steps;
    int unsigned p;
    steps = 0;
    while (steps < NLAB) begin
      p = seg_parent[l-1];
      if (p == 0 || p > NLAB) break;
      l = p;
      steps++;
    end
    return l;
  endfunction

  function automatic longint unsigned members(int unsigned r);
    return (seg_cnt[r-1] == 0) ? 1 : longint'(seg_cnt[r-1]);
  endfunction

  function automatic longint unsigned gap_to(int unsigned r, int unsigned p);
    longint unsigned a;
    longint unsigned s;
    a = longint'(p) * members(r);
    s = seg_sum[r-1];
    return (a > s) ? a - s : s - a;
  endfunction

  function automatic bit near(int unsigned r, int unsigned p);
    return gap_to(r, p) < longint'(delta) * members(r);
  endfunction

  function automatic bit means_near(int unsigned a, int unsigned b);
    longint unsigned x;
    longint unsigned y;
    longint unsigned g;
    x = longint'(seg_sum[a-1]) * members(b);
    y = longint'(seg_sum[b-1]) * members(a);
    g = (x > y) ? x - y : y - x;
    return g < longint'(delta) * members(a) * members(b);
  endfunction

  function automatic void grow(int unsigned r, int unsigned p);
    longint unsigned s;
    s = longint'(seg_sum[r-1]) + p;
    seg_sum[r-1] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    if (seg_cnt[r-1] != 24'hFF_FFFF) seg_cnt[r-1]++;
  endfunction

  function automatic int unsigned join_roots(int unsigned a, int unsigned b);
    int unsigned lo;
    int unsigned hi;
    longint unsigned s;
    longint unsigned c;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi) return lo;
    seg_parent[hi-1] = rrg_pkg::LABEL_W'(lo);
    s = longint'(seg_sum[lo-1]) + seg_sum[hi-1];
    c = longint'(seg_cnt[lo-1]) + seg_cnt[hi-1];
    seg_sum[lo-1] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    seg_cnt[lo-1] = (c > 64'hFF_FFFF) ? 24'hFF_FFFF : c[23:0];
    return lo;
  endfunction

  function automatic int unsigned label_of(int unsigned p, int unsigned up,
                                           int unsigned lf, output bit full);
    int unsigned ru;
    int unsigned rl;
    bit cu;
    bit cl;
    ru = 0;
    rl = 0;
    full = 0;
    if (p == 0) return 0;
    if (in_use(up)) ru = root_of(up);
    else up = 0;
    if (in_use(lf)) rl = root_of(lf);
    else lf = 0;
    cu = up != 0 && near(ru, p);
    cl = lf != 0 && near(rl, p);
    if (!cu && !cl) begin
      if (next_lab > NLAB) begin
        full = 1;
        return 0;
      end
      seg_parent[next_lab-1] = '0;
      seg_sum[next_lab-1] = rrg_pkg::SUM_W'(p);
      seg_cnt[next_lab-1] = rrg_pkg::CNT_W'(1);
      next_lab++;
      return next_lab - 1;
    end
    if (cu && !cl) begin
      grow(ru, p);
      return up;
    end
    if (cl && !cu) begin
      grow(rl, p);
      return lf;
    end
    if (means_near(ru, rl)) return join_roots(ru, rl);
    if (gap_to(ru, p) / members(ru) < gap_to(rl, p) / members(rl)) begin
      grow(ru, p);
      return up;
    end
    grow(rl, p);
    return lf;
  endfunction

  function automatic rrg_pkg::out_t predict(rrg_pkg::in_t beat);
    rrg_pkg::out_t r;
    int unsigned w;
    int unsigned up;
    bit full;
    r = '0;
    if (beat.command == rrg_pkg::CMD_LABEL) begin
      w = width;
      if (w == 0) w = 1;
      if (w > NCOL) w = NCOL;
      if (col >= w) begin
        col = 0;
        left_lab = 0;
        top_row = 0;
      end
      up = top_row ? 0 : row_above[col];
      r.label = rrg_pkg::LABEL_W'(label_of(beat.pixel, up, (col == 0) ? 0 : left_lab, full));
      r.table_full = full;
      row_above[col] = r.label;
      left_lab = r.label;
      col++;
      if (col >= w) begin
        col = 0;
        left_lab = 0;
        top_row = 0;
      end
    end else if (beat.command == rrg_pkg::CMD_RESOLVE) begin
      r.label = in_use(beat.query_label) ?
                rrg_pkg::LABEL_W'(root_of(beat.query_label)) : '0;
    end else if (beat.command == rrg_pkg::CMD_FRAME) begin
      next_lab = 1;
      left_lab = 0;
      col = 0;
      top_row = 1;
    end
    return r;
  endfunction

  task automatic report(string what, rrg_pkg::out_t got, rrg_pkg::out_t want);
    $display("mismatch at %0t: %s got label %0d full %0d, want label %0d full %0d",
             $time, what, got.label, got.table_full, want.label, want.table_full);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rrg_pkg::out_t want;
    if (!rst_n) begin
      delta = rrg_pkg::DELTA_RST;
      width = rrg_pkg::WIDTH_RST;
      left_lab = 0;
      next_lab = 1;
      col = 0;
      top_row = 1;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == rrg_pkg::REG_DELTA) delta = cfg_data[rrg_pkg::DELTA_W-1:0];
        else if (cfg_index == rrg_pkg::REG_WIDTH) width = cfg_data[rrg_pkg::IW_W-1:0];
      end
      if (out_strobe) begin
        if (expected_beats.size() == 0) begin
          report("unexpected beat", out_data, '0);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.label !== want.label) report("label", out_data, want);
          else if (out_data.table_full !== want.table_full)
            report("table_full", out_data, want);
        end
      end
      if (start && !busy) expected_beats = {expected_beats, predict(in_data)};
    end
    pending <= expected_beats.size();
  end
endmodule

>>> tb/testbench.sv
// Top of the raster region grow labeler testbench: clock, reset, stimulus and verdict.
module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                          clk = 0;
  logic                          rst_n = 0;
  logic                          start = 0;
  logic                          busy;
  rrg_pkg::in_t                  in_data = '0;
  logic                          out_strobe;
  rrg_pkg::out_t                 out_data;
  logic                          cfg_we = 0;
  logic [rrg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rrg_pkg::CFG_W-1:0]     cfg_data = '0;
  int                            fail_count;
  int                            pending;
  int                            quiet_cycles = 0;
  bit                            calm = 0;
  int                            idle_pct = 20;
  int                            shade = 128;

  always #5 clk = ~clk;

  raster_region_grow_labeler uut (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  rrg_checker chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 200000) begin
      $display("FAIL raster_region_grow_labeler");
      $finish;
    end
  end

  task automatic send(logic [1:0] c, int p, int q);
    rrg_pkg::in_t beat;
    beat.command = c;
    beat.pixel = p[rrg_pkg::PIX_W-1:0];
    beat.query_label = q[rrg_pkg::LABEL_W-1:0];
    in_data <= beat;
    start <= 1;
    do @(posedge clk); while (busy);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [rrg_pkg::CFG_IDX_W-1:0] idx, int v);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v[rrg_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic pixel_beat();
    int p;
    if ($urandom_range(0, 19) == 0) shade = $urandom_range(1, 255);
    else shade = shade + $urandom_range(0, 12) - 6;
    if (shade < 1) shade = 1;
    if (shade > 255) shade = 255;
    p = shade;
    case ($urandom_range(0, 19))
      0: p = 0;
      1: p = $urandom_range(0, 255);
      default: ;
    endcase
    send(rrg_pkg::CMD_LABEL, p, $urandom_range(0, 8191));
  endtask

  task automatic scene(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 6) send(rrg_pkg::CMD_RESOLVE, $urandom_range(0, 255), $urandom_range(0, 80));
      else if (k < 8)
        send(rrg_pkg::CMD_RESOLVE, $urandom_range(0, 255), $urandom_range(0, 8191));
      else if (k < 9)
        send(rrg_pkg::CMD_FRAME, $urandom_range(0, 255), $urandom_range(0, 8191));
      else if (k < 10) send(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 8191));
      else pixel_beat();
    end
  endtask

  task automatic phase(int d, int w, int n);
    write_reg(rrg_pkg::REG_DELTA, d);
    write_reg(rrg_pkg::REG_WIDTH, w);
    idle_pct = $urandom_range(0, 40);
    send(rrg_pkg::CMD_FRAME, 0, 0);
    scene(n);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(rrg_pkg::REG_WIDTH, 4);
    send(rrg_pkg::CMD_FRAME, 0, 0);
    send(rrg_pkg::CMD_LABEL, 100, 0);
    send(rrg_pkg::CMD_LABEL, 100, 0);
    send(rrg_pkg::CMD_LABEL, 200, 0);
    send(rrg_pkg::CMD_LABEL, 0, 0);
    send(rrg_pkg::CMD_LABEL, 100, 0);
    send(rrg_pkg::CMD_LABEL, 150, 0);
    send(rrg_pkg::CMD_LABEL, 200, 0);
    send(rrg_pkg::CMD_LABEL, 255, 0);
    send(rrg_pkg::CMD_LABEL, 1, 8191);
    send(rrg_pkg::CMD_LABEL, 108, 0);
    send(rrg_pkg::CMD_LABEL, 160, 0);
    send(rrg_pkg::CMD_LABEL, 170, 0);
    send(rrg_pkg::CMD_RESOLVE, 0, 0);
    send(rrg_pkg::CMD_RESOLVE, 0, 1);
    send(rrg_pkg::CMD_RESOLVE, 0, 3);
    send(rrg_pkg::CMD_RESOLVE, 0, 4096);
    send(rrg_pkg::CMD_RESOLVE, 255, 8191);
    send(CMD_UNUSED, 255, 8191);
    send(rrg_pkg::CMD_FRAME, 0, 0);
    send(rrg_pkg::CMD_RESOLVE, 0, 1);

    phase(16, 8, 220);
    phase(0, 5, 120);
    phase(256, 3, 120);
    phase(40, 1, 100);
    phase(8, 1024, 160);
    phase(24, 2047, 120);
    phase(12, 0, 80);
    phase(30, 12, 150);
    write_reg(rrg_pkg::REG_WIDTH, 5);
    scene(100);

    write_reg(rrg_pkg::REG_DELTA, 0);
    write_reg(rrg_pkg::REG_WIDTH, 1024);
    idle_pct = 0;
    send(rrg_pkg::CMD_FRAME, 0, 0);
    for (int i = 0; i < 250; i++) send(rrg_pkg::CMD_LABEL, $urandom_range(1, 255), 0);
    send(rrg_pkg::CMD_RESOLVE, 0, 4096);
    send(rrg_pkg::CMD_RESOLVE, 0, 4095);

    phase(20, 16, 150);
    calm = 1;
    phase(511, 10, 150);

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("PASS raster_region_grow_labeler");
    else $display("FAIL raster_region_grow_labeler");
    $finish;
  end
endmodule
